[sv/index_field_stream_decoder_core_macros.svh]
// Assertion helpers shared by the decoder core.
`ifndef INDEX_FIELD_STREAM_DECODER_CORE_MACROS_SVH
`define INDEX_FIELD_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IFSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ifsd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IFSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ifsd: next-cycle check failed");

`endif

[sv/ifsd_pkg.sv]
package ifsd_pkg;

    localparam int CMD_W   = 3;
    localparam int DATA_W  = 8;
    localparam int VALUE_W = 64;
    localparam int KIND_W  = 3;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF   = 2;

    localparam logic [CMD_W-1:0] CMD_VINT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_VLONG  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INT32  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INT64  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STRING = 3'd4;

    localparam logic [KIND_W-1:0] KIND_VINT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_VLONG = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INT32 = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INT64 = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SLEN  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CHAR  = 3'd5;

    // Classified input beat, front to back.
    typedef struct packed {
        logic              cmd_ok;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] data;
        logic              cont;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [KIND_W-1:0]  kind;
        logic               last;
    } result_t;

    // Back-end status seen by the top level.
    typedef struct packed {
        logic busy;
        logic res_wr;
        logic res_last;
    } back_stat_t;

endpackage

[sv/ifsd_fifo.sv]
module ifsd_fifo
    import ifsd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[sv/ifsd_front.sv]
module ifsd_front
    import ifsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CMD_W-1:0]  command,
    input  logic [DATA_W-1:0] data_byte,
    output logic              item_valid,
    output item_t             item,
    input  logic              item_take
);

    item_t cls;
    logic  q_empty;

    // Tag each beat: command validity and varint continuation bit.
    always_comb
    begin
        cls.cmd_ok = command inside {[CMD_VINT:CMD_STRING]};
        cls.cmd    = command;
        cls.data   = data_byte;
        cls.cont   = data_byte[DATA_W-1];
    end

    ifsd_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls),
        .full    (full),
        .rd_en   (item_take),
        .rd_data (item),
        .empty   (q_empty)
    );

    assign item_valid = !q_empty;

endmodule

[sv/ifsd_back.sv]
module ifsd_back
    import ifsd_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  item_t                     item,
    output logic                      item_take,
    output back_stat_t                stat,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [VALUE_W-1:0] value,
    output logic [KIND_W-1:0]         kind,
    output logic                      last
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_VINT,
        MODE_VLONG,
        MODE_INT32,
        MODE_INT64,
        MODE_SLEN,
        MODE_SCHAR
    } mode_t;

    localparam logic [6:0] SHIFT_STEP = 7'd7;
    localparam logic [6:0] SHIFT_SAT  = 7'd70;

    mode_t              mode_reg, mode_next, mode_cur;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic [15:0]        chr_reg, chr_next;
    logic [1:0]         utf_reg, utf_next;
    logic [31:0]        chars_reg, chars_next;

    logic               res_full;
    logic               fire;
    logic               res_wr;
    result_t            res;
    result_t            res_out;
    logic               go_idle;

    logic               wide;
    logic               shift_in;
    logic [VALUE_W-1:0] vacc;
    logic [VALUE_W-1:0] sext;
    logic [6:0]         vcnt;
    logic [VALUE_W-1:0] facc;
    logic [6:0]         fcnt;
    logic [6:0]         need;
    logic [1:0]         utf_dec;
    logic [15:0]        ch;
    logic               ch_done;
    logic [31:0]        chars_dec;

    assign fire      = item_valid && !res_full;
    assign item_take = fire;

    always_comb
    begin
        mode_cur = mode_reg;
        if (mode_reg == MODE_IDLE)
        begin
            case (item.cmd)
                CMD_VINT:   mode_cur = MODE_VINT;
                CMD_VLONG:  mode_cur = MODE_VLONG;
                CMD_INT32:  mode_cur = MODE_INT32;
                CMD_INT64:  mode_cur = MODE_INT64;
                CMD_STRING: mode_cur = MODE_SLEN;
                default:    mode_cur = MODE_IDLE;
            endcase
        end
    end

    // Datapath pieces, one per decode kind.
    always_comb
    begin
        wide     = (mode_cur == MODE_VLONG);
        shift_in = wide ? (cnt_reg < 7'd64) : (cnt_reg < 7'd32);
        vacc     = acc_reg;
        if (shift_in)
        begin
            vacc = acc_reg | (VALUE_W'(item.data[6:0]) << cnt_reg[5:0]);
        end
        if (!wide)
        begin
            vacc[VALUE_W-1:32] = '0;
        end
        sext = {{32{vacc[31]}}, vacc[31:0]};
        vcnt = (cnt_reg < SHIFT_SAT) ? cnt_reg + SHIFT_STEP : cnt_reg;

        facc = {acc_reg[VALUE_W-9:0], item.data};
        fcnt = cnt_reg + 7'd1;
        need = (mode_cur == MODE_INT32) ? 7'd4 : 7'd8;

        utf_dec   = utf_reg - 2'd1;
        chars_dec = chars_reg - 32'd1;
        ch        = '0;
        ch_done   = 1'b0;
        if (utf_reg == 2'd0)
        begin
            ch      = {9'd0, item.data[6:0]};
            ch_done = !item.data[7];
        end
        else
        begin
            ch      = chr_reg | ((utf_dec == 2'd1) ? {4'd0, item.data[5:0], 6'd0}
                                                   : {10'd0, item.data[5:0]});
            ch_done = (utf_dec == 2'd0);
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        chr_next   = chr_reg;
        utf_next   = utf_reg;
        chars_next = chars_reg;
        res_wr     = 1'b0;
        res        = '0;
        go_idle    = 1'b0;

        if (fire && (mode_reg != MODE_IDLE || item.cmd_ok))
        begin
            mode_next = mode_cur;
            case (mode_cur)
                MODE_VINT, MODE_VLONG, MODE_SLEN:
                begin
                    acc_next = vacc;
                    cnt_next = vcnt;
                    if (!item.cont)
                    begin
                        res_wr = 1'b1;
                        if (mode_cur == MODE_VINT)
                        begin
                            res     = '{value: sext, kind: KIND_VINT, last: 1'b1};
                            go_idle = 1'b1;
                        end
                        else if (mode_cur == MODE_VLONG)
                        begin
                            res     = '{value: vacc, kind: KIND_VLONG, last: 1'b1};
                            go_idle = 1'b1;
                        end
                        else if (vacc[31] || vacc[31:0] == 32'd0)
                        begin
                            // Empty or negative length ends the string here.
                            res     = '{value: sext, kind: KIND_SLEN, last: 1'b1};
                            go_idle = 1'b1;
                        end
                        else
                        begin
                            res        = '{value: sext, kind: KIND_SLEN, last: 1'b0};
                            chars_next = vacc[31:0];
                            mode_next  = MODE_SCHAR;
                            acc_next   = '0;
                            cnt_next   = '0;
                            chr_next   = '0;
                            utf_next   = '0;
                        end
                    end
                end
                MODE_INT32, MODE_INT64:
                begin
                    acc_next = facc;
                    cnt_next = fcnt;
                    if (fcnt >= need)
                    begin
                        res_wr  = 1'b1;
                        go_idle = 1'b1;
                        if (mode_cur == MODE_INT32)
                        begin
                            res = '{value: {{32{facc[31]}}, facc[31:0]}, kind: KIND_INT32,
                                    last: 1'b1};
                        end
                        else
                        begin
                            res = '{value: facc, kind: KIND_INT64, last: 1'b1};
                        end
                    end
                end
                MODE_SCHAR:
                begin
                    if (utf_reg == 2'd0 && item.data[7])
                    begin
                        if (item.data[7:5] != 3'b111)
                        begin
                            chr_next = {5'd0, item.data[4:0], 6'd0};
                            utf_next = 2'd1;
                        end
                        else
                        begin
                            chr_next = {item.data[3:0], 12'd0};
                            utf_next = 2'd2;
                        end
                    end
                    else if (!ch_done)
                    begin
                        chr_next = ch;
                        utf_next = utf_dec;
                    end
                    else
                    begin
                        res_wr     = 1'b1;
                        chr_next   = '0;
                        utf_next   = '0;
                        chars_next = chars_dec;
                        if (chars_dec == 32'd0)
                        begin
                            res     = '{value: VALUE_W'(ch), kind: KIND_CHAR, last: 1'b1};
                            go_idle = 1'b1;
                        end
                        else
                        begin
                            res = '{value: VALUE_W'(ch), kind: KIND_CHAR, last: 1'b0};
                        end
                    end
                end
                default:
                begin
                    go_idle = 1'b1;
                end
            endcase
        end

        if (go_idle)
        begin
            mode_next  = MODE_IDLE;
            acc_next   = '0;
            cnt_next   = '0;
            chr_next   = '0;
            utf_next   = '0;
            chars_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            chr_reg   <= '0;
            utf_reg   <= '0;
            chars_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            chr_reg   <= chr_next;
            utf_reg   <= utf_next;
            chars_reg <= chars_next;
        end
    end

    ifsd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign value = res_out.value;
    assign kind  = res_out.kind;
    assign last  = res_out.last;

    assign stat.busy     = (mode_reg != MODE_IDLE);
    assign stat.res_wr   = res_wr;
    assign stat.res_last = res.last;

endmodule

[sv/index_field_stream_decoder_core.sv]
// Index field stream decoder. Takes one index-file byte per beat and decodes
// vint/vlong varints, big-endian int32/int64 and strings (varint length, then
// modified UTF-8 characters returned as 16-bit code units), one result per
// completed value, length or character, with last marking the end of the
// request. The command is only sampled on the first byte of a value. Sustained
// rate is one byte per clock: the decode engine retires one queued byte every
// cycle while the result queue has room. A byte that completes a result passes
// through the input queue and is then decoded into the result queue, where it
// can be popped.
`include "index_field_stream_decoder_core_macros.svh"

module index_field_stream_decoder_core
    import ifsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int OUT_DEPTH   = OUT_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [CMD_W-1:0]          command,
    input  logic [DATA_W-1:0]         data_byte,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [VALUE_W-1:0] value,
    output logic [KIND_W-1:0]         kind,
    output logic                      last
);

    logic       item_valid;
    item_t      item;
    logic       item_take;
    back_stat_t stat;

    ifsd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .data_byte  (data_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    ifsd_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .stat       (stat),
        .empty      (empty),
        .pop        (pop),
        .value      (value),
        .kind       (kind),
        .last       (last)
    );

    // An accepted beat is queued for the back end on the next cycle.
    `IFSD_ASSERT_NEXT(a_push_queued, clk, rst_n, push && !full, item_valid)
    // A final result returns the decoder to idle.
    `IFSD_ASSERT_NEXT(a_last_idles, clk, rst_n, stat.res_wr && stat.res_last, !stat.busy)
    // Only defined result kinds leave the block.
    `IFSD_ASSERT_NOW(a_kind_legal, clk, rst_n, !empty, kind <= KIND_CHAR)

endmodule
